@@ rtl/odo_pkg.sv @@
// Shared constants, types and tables for the differential-drive odometry block.
// Used by the multiplier, the CORDIC unit and the top level; depends on nothing.
package odo_pkg;

  // Encoder counter width kept between readings, and CORDIC length
  localparam int COUNT_BITS   = 16;
  localparam int CORDIC_STEPS = 24;

  // Wheel travel product width (count delta times 33-bit unsigned scale)
  localparam int PW      = COUNT_BITS + 33;
  // Mean travel in Q18.16 after the halving and the 16-bit drop
  localparam int CTR_W   = PW - 15;
  // Shared multiplier operand and product widths
  localparam int MUL_AW  = (CTR_W > 33) ? CTR_W : 33;
  localparam int MUL_BW  = 33;
  localparam int PROD_W  = MUL_AW + MUL_BW;
  // Width used for saturation compares
  localparam int SW      = PROD_W + 1;

  // CORDIC datapath
  localparam int CORD_W  = 34;
  localparam int IDX_W   = $clog2(CORDIC_STEPS);
  localparam int ATAN_IW = 5;
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = CORD_W'(652032874);

  // Configuration register indexes
  localparam logic [1:0] REG_DIST_PER_COUNT  = 2'd0;
  localparam logic [1:0] REG_TURNS_PER_METER = 2'd1;
  localparam logic [1:0] REG_UPDATE_RATE     = 2'd2;

  // Arctangent of two to the minus i, binary angle
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // CORDIC request and result between sequencer and rotator
  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [CORD_W-1:0] cos_val;
    logic signed [CORD_W-1:0] sin_val;
  } cordic_res_t;

endpackage

@@ rtl/odo_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on odo_pkg for operand and product widths.
module odo_mul import odo_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  // Multiply and register
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ rtl/odo_cordic.sv @@
// Iterative CORDIC rotator: cosine and sine of a binary angle, one step per cycle.
// Depends on odo_pkg for widths, the arctangent table and the request/result types.
module odo_cordic import odo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_res_t res
);

  localparam logic signed [CORD_W-1:0] QUARTER = CORD_W'(64'sd1073741824);
  localparam logic signed [CORD_W-1:0] HALF    = CORD_W'(64'sd2147483648);

  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic signed [CORD_W-1:0] z;
  logic [IDX_W-1:0]         idx;
  logic                     busy;
  logic                     done;
  logic                     neg;

  logic signed [CORD_W-1:0] z_in;
  logic signed [CORD_W-1:0] x_sh;
  logic signed [CORD_W-1:0] y_sh;
  logic signed [CORD_W-1:0] atan_step;

  // Sign-extend the start angle; the fold into the right half plane happens on load
  always_comb begin
    z_in = CORD_W'(signed'(req.angle));
  end

  assign x_sh      = x >>> idx;
  assign y_sh      = y >>> idx;
  assign atan_step = signed'({{(CORD_W-32){1'b0}}, ATAN_TAB[ATAN_IW'(idx)]});

  // Load on start, then rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      x    <= CORDIC_X0;
      y    <= '0;
      idx  <= '0;
      if (z_in > QUARTER) begin
        z   <= z_in - HALF;
        neg <= 1'b1;
      end else if (z_in < -QUARTER) begin
        z   <= z_in + HALF;
        neg <= 1'b1;
      end else begin
        z   <= z_in;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (!z[CORD_W-1]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_step;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_step;
      end
      if (idx == IDX_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Undo the fold on the way out
  assign res.done    = done;
  assign res.cos_val = neg ? -x : x;
  assign res.sin_val = neg ? -y : y;

endmodule

@@ rtl/diff_drive_odometry.sv @@
// Differential-drive wheel odometry: sequencer, state and output register.
// Depends on odo_pkg, odo_mul (shared multiplier) and odo_cordic (rotator).
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | left_count, right_count
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | pos_x, pos_y, heading, speed, turn
//  cfg       | in  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// Per beat, the CORDIC starts on accept and runs its CORDIC_STEPS rotation steps
// while the shared multiplier works through travel and speeds, then two multiplies rotate
// the step into x and y before the result is registered; s_axis_tready is high
// only when idle. A finished result waits in the output register while the next beat is
// taken; the block stalls at its last step only if the previous result is still not taken.
// Synchronous reset restores default registers and zero position, heading and counts.
module diff_drive_odometry import odo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [15:0] left_count, [31:16] right_count
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [183:0] m_axis_tdata,   // [31:0] pos_x, [63:32] pos_y,
                                       // [95:64] heading_angle, [137:96] forward_speed,
                                       // [179:138] turn_rate, [183:180] zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PL   = 4'd1;
  localparam logic [3:0] ST_PR   = 4'd2;
  localparam logic [3:0] ST_DIFF = 4'd3;
  localparam logic [3:0] ST_LO   = 4'd4;
  localparam logic [3:0] ST_HI   = 4'd5;
  localparam logic [3:0] ST_DTH  = 4'd6;
  localparam logic [3:0] ST_SPD  = 4'd7;
  localparam logic [3:0] ST_RATE = 4'd8;
  localparam logic [3:0] ST_WAIT = 4'd9;
  localparam logic [3:0] ST_X    = 4'd10;
  localparam logic [3:0] ST_Y    = 4'd11;
  localparam logic [3:0] ST_POSY = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  localparam logic signed [SW-1:0] MAX32 = SW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SW-1:0] MIN32 = SW'(-64'sh0000_0000_8000_0000);
  localparam logic signed [SW-1:0] MAX42 = SW'(64'sh0000_01FF_FFFF_FFFF);
  localparam logic signed [SW-1:0] MIN42 = SW'(-64'sh0000_0200_0000_0000);

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > MAX32) return 32'sh7FFF_FFFF;
    else if (v < MIN32) return 32'sh8000_0000;
    else return signed'(v[31:0]);
  endfunction

  function automatic logic [41:0] sat42(input logic signed [SW-1:0] v);
    if (v > MAX42) return 42'h1FF_FFFF_FFFF;
    else if (v < MIN42) return 42'h200_0000_0000;
    else return v[41:0];
  endfunction

  // Configuration registers
  logic [31:0] dist_per_count;
  logic [23:0] turns_per_meter;
  logic [9:0]  update_rate_hz;

  // Odometry state
  logic [COUNT_BITS-1:0] prev_left;
  logic [COUNT_BITS-1:0] prev_right;
  logic signed [31:0]    pos_x_acc;
  logic signed [31:0]    pos_y_acc;
  logic [31:0]           heading_acc;

  // Per-beat working registers
  logic [3:0]                   state;
  logic signed [COUNT_BITS-1:0] dl;
  logic signed [COUNT_BITS-1:0] dr;
  logic signed [PW-1:0]         pl;
  logic [47:0]                  diff48;
  logic signed [CTR_W-1:0]      center;
  logic [47:0]                  lo_prod;
  logic [31:0]                  dth;
  logic [41:0]                  speed;
  logic [41:0]                  turn;

  // Shared units
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  cordic_req_t              creq;
  cordic_res_t              cres;

  // Combinational helpers
  logic [COUNT_BITS-1:0] cur_left;
  logic [COUNT_BITS-1:0] cur_right;
  logic signed [PW-1:0]  pr_w;
  logic signed [PW:0]    half_sum;
  logic signed [PW:0]    diff_full;
  logic signed [31:0]    stepv;
  logic signed [SW-1:0]  pos_sum;
  logic                  accept;
  logic                  out_free;

  odo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  odo_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .res (cres)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Start the rotation on the old heading as the beat is taken
  assign creq.start = accept;
  assign creq.angle = heading_acc;

  // Counts as kept between readings, wheel sums, clamped step
  assign cur_left  = COUNT_BITS'(signed'(s_axis_tdata[15:0]));
  assign cur_right = COUNT_BITS'(signed'(s_axis_tdata[31:16]));
  assign pr_w      = prod[PW-1:0];
  assign half_sum  = (PW+1)'(pl >>> 1) + (PW+1)'(pr_w >>> 1);
  assign diff_full = (PW+1)'(pr_w) - (PW+1)'(pl);
  assign stepv     = sat32(SW'(center));
  assign pos_sum   = SW'(signed'(prod[PROD_W-1:30]))
                   + SW'((state == ST_Y) ? pos_x_acc : pos_y_acc);

  // Pick multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_PL: begin
        mul_a = MUL_AW'(dl);
        mul_b = signed'({1'b0, dist_per_count});
      end
      ST_PR: begin
        mul_a = MUL_AW'(dr);
        mul_b = signed'({1'b0, dist_per_count});
      end
      ST_LO: begin
        mul_a = MUL_AW'(signed'({1'b0, diff48[23:0]}));
        mul_b = MUL_BW'(signed'({1'b0, turns_per_meter}));
      end
      ST_HI: begin
        mul_a = MUL_AW'(signed'({1'b0, diff48[47:24]}));
        mul_b = MUL_BW'(signed'({1'b0, turns_per_meter}));
      end
      ST_SPD: begin
        mul_a = MUL_AW'(center);
        mul_b = MUL_BW'(signed'({1'b0, update_rate_hz}));
      end
      // Keep the turn rate product steady while the rotator finishes
      ST_RATE, ST_WAIT: begin
        mul_a = MUL_AW'(signed'(dth));
        mul_b = MUL_BW'(signed'({1'b0, update_rate_hz}));
      end
      ST_X: begin
        mul_a = MUL_AW'(stepv);
        mul_b = MUL_BW'(cres.cos_val);
      end
      ST_Y: begin
        mul_a = MUL_AW'(stepv);
        mul_b = MUL_BW'(cres.sin_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count  <= 32'd614180;
      turns_per_meter <= 24'd61355;
      update_rate_hz  <= 10'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIST_PER_COUNT:  dist_per_count  <= cfg_data;
        REG_TURNS_PER_METER: turns_per_meter <= cfg_data[23:0];
        REG_UPDATE_RATE:     update_rate_hz  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer, state updates and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      prev_left     <= '0;
      prev_right    <= '0;
      pos_x_acc     <= '0;
      pos_y_acc     <= '0;
      heading_acc   <= '0;
    end else begin
      // Retire a taken result unless a new one replaces it
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            dl         <= signed'(cur_left - prev_left);
            dr         <= signed'(cur_right - prev_right);
            prev_left  <= cur_left;
            prev_right <= cur_right;
            state      <= ST_PL;
          end
        end
        ST_PL: state <= ST_PR;
        ST_PR: begin
          pl    <= prod[PW-1:0];
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          diff48 <= 48'(diff_full);
          center <= CTR_W'(half_sum >>> 16);
          state  <= ST_LO;
        end
        ST_LO: state <= ST_HI;
        ST_HI: begin
          lo_prod <= prod[47:0];
          state   <= ST_DTH;
        end
        ST_DTH: begin
          dth   <= lo_prod[47:16] + {prod[23:0], 8'b0};
          state <= ST_SPD;
        end
        ST_SPD: state <= ST_RATE;
        ST_RATE: begin
          speed <= sat42(SW'(prod));
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          turn <= prod[41:0];
          if (cres.done) begin
            state <= ST_X;
          end
        end
        ST_X: state <= ST_Y;
        ST_Y: begin
          pos_x_acc <= sat32(pos_sum);
          state     <= ST_POSY;
        end
        ST_POSY: begin
          pos_y_acc   <= sat32(pos_sum);
          heading_acc <= heading_acc + dth;
          state       <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the previous result has left
          if (out_free) begin
            m_axis_tdata  <= {4'b0, turn, speed, heading_acc, pos_y_acc, pos_x_acc};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
